// ----- sv/rbt_pkg.sv -----
package rbt_pkg;

   localparam int DEF_TIME_WIDTH    = 32;
   localparam int DEF_COUNT_WIDTH   = 16;
   localparam int FIELD_COUNT_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH   = 3;

   localparam int unsigned RESET_BASE_INTERVAL   = 500;
   localparam int unsigned RESET_TOTAL_TIMEOUT   = 60000;
   localparam int unsigned RESET_MAX_RETRANSMITS = 12;

   typedef enum logic [1:0] {
      MODE_CLEAR,
      MODE_START,
      MODE_EXPIRY,
      MODE_DUPLICATE
   } mode_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_RETRANSMIT,
      ACT_SKIPPED,
      ACT_TIMEOUT,
      ACT_FORCED
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BASE_INTERVAL,
      CSR_TOTAL_TIMEOUT,
      CSR_MAX_RETRANSMITS,
      CSR_SUPPRESS_MODE,
      CSR_FORCE_TIMEOUT_MODE,
      CSR_STREAM_TRANSPORT
   } csr_index_type;

   typedef struct packed {
      action_type action;
      logic       duplicate_accepted;
      logic       schedule_valid;
      logic       cancel_timer;
   } rsp_flags_type;

endpackage

// ----- sv/rbt_channels_if.sv -----
interface rbt_req_if #(parameter int TIME_WIDTH = rbt_pkg::DEF_TIME_WIDTH);
   logic                                  valid;
   logic                                  ready;
   rbt_pkg::mode_type                     mode;
   logic [TIME_WIDTH-1:0]                 now_ms;
   logic [rbt_pkg::FIELD_COUNT_WIDTH-1:0] duplicate_limit;

   modport source (output valid, mode, now_ms, duplicate_limit, input ready);
   modport sink (input valid, mode, now_ms, duplicate_limit, output ready);
endinterface

interface rbt_rsp_if #(parameter int TIME_WIDTH = rbt_pkg::DEF_TIME_WIDTH);
   logic                                  valid;
   logic                                  ready;
   rbt_pkg::action_type                   action;
   logic                                  duplicate_accepted;
   logic                                  schedule_valid;
   logic [TIME_WIDTH-1:0]                 schedule_delay;
   logic [rbt_pkg::FIELD_COUNT_WIDTH-1:0] total_count;
   logic                                  cancel_timer;

   modport source (output valid, action, duplicate_accepted, schedule_valid, schedule_delay,
                   total_count, cancel_timer, input ready);
   modport sink (input valid, action, duplicate_accepted, schedule_valid, schedule_delay,
                 total_count, cancel_timer, output ready);
endinterface

interface rbt_csr_if #(parameter int DATA_WIDTH = rbt_pkg::DEF_TIME_WIDTH);
   logic                                valid;
   logic                                ready;
   logic [rbt_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [DATA_WIDTH-1:0]               data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/retransmit_backoff_timer.sv -----
// Capped exponential backoff retransmit timer.
// req_chan: one event per request (clear, start, timer expiry, duplicate reply)
//   with the current millisecond time and the duplicate cap.
// rsp_chan: exactly one result per request: action, duplicate acceptance,
//   timer event to schedule with its delay, total count, timer cancel.
// csr_chan: register writes, always ready; data width must be at least the
//   wider of TIME_WIDTH and COUNT_WIDTH. Write only while the block is idle.
// Path: an accepted request passes through the input register, then the
//   result register, before its result appears on rsp_chan.
// Throughput: one request per cycle unless stalled; the state update is a
//   single pass of add/compare logic between the input and result registers.
// Stall: a held result keeps rsp_chan.valid high; the input register still
//   takes one more request, after which req_chan.ready drops.
// Reset: all counters, delays and limits zero; registers return to their
//   defaults (500 ms base, 60000 ms timeout, 12 retransmits, modes off).
module retransmit_backoff_timer #(
   parameter int TIME_WIDTH  = rbt_pkg::DEF_TIME_WIDTH,
   parameter int COUNT_WIDTH = rbt_pkg::DEF_COUNT_WIDTH
) (
   input logic        clock,
   input logic        reset,
   rbt_req_if.sink    req_chan,
   rbt_rsp_if.source  rsp_chan,
   rbt_csr_if.sink    csr_chan
);
   import rbt_pkg::*;

   logic [TIME_WIDTH-1:0]        base_interval_ff;
   logic [TIME_WIDTH-1:0]        total_timeout_ff;
   logic [COUNT_WIDTH-1:0]       max_retransmits_ff;
   logic                         suppress_mode_ff;
   logic                         force_timeout_mode_ff;
   logic                         stream_transport_ff;

   logic                         s1_valid_ff;
   mode_type                     s1_mode_ff;
   logic [TIME_WIDTH-1:0]        s1_now_ff;
   logic [FIELD_COUNT_WIDTH-1:0] s1_dup_limit_ff;

   logic [COUNT_WIDTH-1:0]       retransmit_tally_ff, retransmit_tally_in;
   logic [COUNT_WIDTH-1:0]       duplicate_tally_ff, duplicate_tally_in;
   logic [TIME_WIDTH-1:0]        current_delay_ff, current_delay_in;
   logic [TIME_WIDTH-1:0]        accumulated_delay_ff, accumulated_delay_in;
   logic [TIME_WIDTH-1:0]        start_time_ff, start_time_in;
   logic [TIME_WIDTH-1:0]        active_timeout_ff, active_timeout_in;
   logic [COUNT_WIDTH-1:0]       active_limit_ff, active_limit_in;

   logic                         rsp_valid_ff;
   rsp_flags_type                rsp_flags_ff, rsp_flags_in;
   logic [TIME_WIDTH-1:0]        rsp_delay_ff, rsp_delay_in;
   logic [FIELD_COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic                         advance;
   logic                         out_free;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = s1_valid_ff && out_free;
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   rbt_step #(
      .TIME_WIDTH  (TIME_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .mode                 (s1_mode_ff),
      .now_ms               (s1_now_ff),
      .duplicate_limit      (s1_dup_limit_ff),
      .base_interval        (base_interval_ff),
      .total_timeout        (total_timeout_ff),
      .max_retransmits      (max_retransmits_ff),
      .suppress_mode        (suppress_mode_ff),
      .force_timeout_mode   (force_timeout_mode_ff),
      .stream_transport     (stream_transport_ff),
      .retransmit_tally     (retransmit_tally_ff),
      .duplicate_tally      (duplicate_tally_ff),
      .current_delay        (current_delay_ff),
      .accumulated_delay    (accumulated_delay_ff),
      .start_time           (start_time_ff),
      .active_timeout       (active_timeout_ff),
      .active_limit         (active_limit_ff),
      .retransmit_tally_in  (retransmit_tally_in),
      .duplicate_tally_in   (duplicate_tally_in),
      .current_delay_in     (current_delay_in),
      .accumulated_delay_in (accumulated_delay_in),
      .start_time_in        (start_time_in),
      .active_timeout_in    (active_timeout_in),
      .active_limit_in      (active_limit_in),
      .flags                (rsp_flags_in),
      .schedule_delay       (rsp_delay_in),
      .total_count          (rsp_count_in)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_interval_ff      <= TIME_WIDTH'(RESET_BASE_INTERVAL);
         total_timeout_ff      <= TIME_WIDTH'(RESET_TOTAL_TIMEOUT);
         max_retransmits_ff    <= COUNT_WIDTH'(RESET_MAX_RETRANSMITS);
         suppress_mode_ff      <= 1'b0;
         force_timeout_mode_ff <= 1'b0;
         stream_transport_ff   <= 1'b0;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_BASE_INTERVAL:      base_interval_ff      <= csr_chan.data[TIME_WIDTH-1:0];
            CSR_TOTAL_TIMEOUT:      total_timeout_ff      <= csr_chan.data[TIME_WIDTH-1:0];
            CSR_MAX_RETRANSMITS:    max_retransmits_ff    <= csr_chan.data[COUNT_WIDTH-1:0];
            CSR_SUPPRESS_MODE:      suppress_mode_ff      <= csr_chan.data[0];
            CSR_FORCE_TIMEOUT_MODE: force_timeout_mode_ff <= csr_chan.data[0];
            CSR_STREAM_TRANSPORT:   stream_transport_ff   <= csr_chan.data[0];
            default: begin
            end
         endcase
      end
   end

   // input register, timer state, result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         retransmit_tally_ff  <= '0;
         duplicate_tally_ff   <= '0;
         current_delay_ff     <= '0;
         accumulated_delay_ff <= '0;
         start_time_ff        <= '0;
         active_timeout_ff    <= '0;
         active_limit_ff      <= '0;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (advance) begin
            retransmit_tally_ff  <= retransmit_tally_in;
            duplicate_tally_ff   <= duplicate_tally_in;
            current_delay_ff     <= current_delay_in;
            accumulated_delay_ff <= accumulated_delay_in;
            start_time_ff        <= start_time_in;
            active_timeout_ff    <= active_timeout_in;
            active_limit_ff      <= active_limit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_mode_ff      <= req_chan.mode;
         s1_now_ff       <= req_chan.now_ms;
         s1_dup_limit_ff <= req_chan.duplicate_limit;
      end
      if (advance) begin
         rsp_flags_ff <= rsp_flags_in;
         rsp_delay_ff <= rsp_delay_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.action             = rsp_flags_ff.action;
   assign rsp_chan.duplicate_accepted = rsp_flags_ff.duplicate_accepted;
   assign rsp_chan.schedule_valid     = rsp_flags_ff.schedule_valid;
   assign rsp_chan.schedule_delay     = rsp_delay_ff;
   assign rsp_chan.total_count        = rsp_count_ff;
   assign rsp_chan.cancel_timer       = rsp_flags_ff.cancel_timer;

   a_retransmit_counts: assert property (@(posedge clock) disable iff (reset)
      (advance && rsp_flags_in.action == ACT_RETRANSMIT) |=> (retransmit_tally_ff != '0))
      else $error("retransmit result left retransmit tally at zero");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_mode_ff == MODE_CLEAR) |=>
      (retransmit_tally_ff == '0 && duplicate_tally_ff == '0 && rsp_chan.cancel_timer &&
       rsp_chan.total_count == '0))
      else $error("clear did not empty the tallies");

   a_duplicate_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flags_ff.duplicate_accepted) |->
      (!rsp_flags_ff.schedule_valid && rsp_flags_ff.action == ACT_NONE))
      else $error("accepted duplicate also scheduled or acted");

endmodule

// ----- sv/rbt_step.sv -----
module rbt_step #(
   parameter int TIME_WIDTH  = rbt_pkg::DEF_TIME_WIDTH,
   parameter int COUNT_WIDTH = rbt_pkg::DEF_COUNT_WIDTH
) (
   input  rbt_pkg::mode_type                     mode,
   input  logic [TIME_WIDTH-1:0]                 now_ms,
   input  logic [rbt_pkg::FIELD_COUNT_WIDTH-1:0] duplicate_limit,
   input  logic [TIME_WIDTH-1:0]                 base_interval,
   input  logic [TIME_WIDTH-1:0]                 total_timeout,
   input  logic [COUNT_WIDTH-1:0]                max_retransmits,
   input  logic                                  suppress_mode,
   input  logic                                  force_timeout_mode,
   input  logic                                  stream_transport,
   input  logic [COUNT_WIDTH-1:0]                retransmit_tally,
   input  logic [COUNT_WIDTH-1:0]                duplicate_tally,
   input  logic [TIME_WIDTH-1:0]                 current_delay,
   input  logic [TIME_WIDTH-1:0]                 accumulated_delay,
   input  logic [TIME_WIDTH-1:0]                 start_time,
   input  logic [TIME_WIDTH-1:0]                 active_timeout,
   input  logic [COUNT_WIDTH-1:0]                active_limit,
   output logic [COUNT_WIDTH-1:0]                retransmit_tally_in,
   output logic [COUNT_WIDTH-1:0]                duplicate_tally_in,
   output logic [TIME_WIDTH-1:0]                 current_delay_in,
   output logic [TIME_WIDTH-1:0]                 accumulated_delay_in,
   output logic [TIME_WIDTH-1:0]                 start_time_in,
   output logic [TIME_WIDTH-1:0]                 active_timeout_in,
   output logic [COUNT_WIDTH-1:0]                active_limit_in,
   output rbt_pkg::rsp_flags_type                flags,
   output logic [TIME_WIDTH-1:0]                 schedule_delay,
   output logic [rbt_pkg::FIELD_COUNT_WIDTH-1:0] total_count
);
   import rbt_pkg::*;

   localparam int SUM_WIDTH = COUNT_WIDTH + 1;
   localparam int CMP_WIDTH = (SUM_WIDTH > FIELD_COUNT_WIDTH) ? SUM_WIDTH : FIELD_COUNT_WIDTH;

   logic [SUM_WIDTH-1:0]   count_before;
   logic [SUM_WIDTH-1:0]   count_after;
   logic [TIME_WIDTH-1:0]  waited;
   logic [TIME_WIDTH-1:0]  doubled;
   logic [TIME_WIDTH-1:0]  grown_delay;
   logic [TIME_WIDTH-1:0]  first_delay;
   logic [TIME_WIDTH:0]    acc_sum;
   logic [COUNT_WIDTH-1:0] retransmit_inc;
   logic [COUNT_WIDTH-1:0] duplicate_inc;
   logic                   grow_ok;
   logic                   limit_hit;
   logic                   dup_ok;

   always_comb begin
      count_before   = SUM_WIDTH'(retransmit_tally) + SUM_WIDTH'(duplicate_tally);
      waited         = now_ms - start_time;
      doubled        = {current_delay[TIME_WIDTH-2:0], 1'b0};
      grow_ok        = (count_before != '0) && !current_delay[TIME_WIDTH-1] &&
                       (doubled < active_timeout);
      grown_delay    = grow_ok ? doubled : current_delay;
      first_delay    = suppress_mode ? total_timeout : base_interval;
      acc_sum        = {1'b0, accumulated_delay} + {1'b0, grown_delay};
      retransmit_inc = (&retransmit_tally) ? retransmit_tally
                                           : retransmit_tally + COUNT_WIDTH'(1);
      duplicate_inc  = (&duplicate_tally) ? duplicate_tally
                                          : duplicate_tally + COUNT_WIDTH'(1);
      limit_hit      = (count_before >= SUM_WIDTH'(active_limit)) ||
                       (waited >= active_timeout) || (accumulated_delay >= active_timeout);
      dup_ok         = CMP_WIDTH'(count_before) < CMP_WIDTH'(duplicate_limit);

      retransmit_tally_in  = retransmit_tally;
      duplicate_tally_in   = duplicate_tally;
      current_delay_in     = current_delay;
      accumulated_delay_in = accumulated_delay;
      start_time_in        = start_time;
      active_timeout_in    = active_timeout;
      active_limit_in      = active_limit;
      flags.action             = ACT_NONE;
      flags.duplicate_accepted = 1'b0;
      flags.schedule_valid     = 1'b0;
      flags.cancel_timer       = 1'b0;
      schedule_delay           = '0;

      case (mode)
         MODE_CLEAR: begin
            retransmit_tally_in = '0;
            duplicate_tally_in  = '0;
            active_limit_in     = '0;
            current_delay_in    = '0;
            start_time_in       = '0;
            active_timeout_in   = '0;
            flags.cancel_timer  = 1'b1;
         end
         MODE_START: begin
            retransmit_tally_in  = '0;
            duplicate_tally_in   = '0;
            active_limit_in      = max_retransmits;
            active_timeout_in    = total_timeout;
            current_delay_in     = first_delay;
            start_time_in        = now_ms;
            accumulated_delay_in = first_delay;
            flags.schedule_valid = 1'b1;
            schedule_delay       = first_delay;
         end
         MODE_EXPIRY: begin
            if (force_timeout_mode) begin
               flags.action = ACT_FORCED;
            end else if (stream_transport) begin
               flags.action = ACT_SKIPPED;
            end else if (limit_hit) begin
               flags.action = ACT_TIMEOUT;
            end else begin
               current_delay_in     = grown_delay;
               retransmit_tally_in  = retransmit_inc;
               accumulated_delay_in = acc_sum[TIME_WIDTH] ? '1 : acc_sum[TIME_WIDTH-1:0];
               flags.action         = ACT_RETRANSMIT;
               flags.schedule_valid = 1'b1;
               schedule_delay       = grown_delay;
            end
         end
         MODE_DUPLICATE: begin
            if (dup_ok) begin
               current_delay_in         = grown_delay;
               duplicate_tally_in       = duplicate_inc;
               flags.duplicate_accepted = 1'b1;
            end
         end
         default: begin
         end
      endcase

      count_after = SUM_WIDTH'(retransmit_tally_in) + SUM_WIDTH'(duplicate_tally_in);
      if (CMP_WIDTH'(count_after) > CMP_WIDTH'({FIELD_COUNT_WIDTH{1'b1}})) begin
         total_count = '1;
      end else begin
         total_count = FIELD_COUNT_WIDTH'(count_after);
      end
   end

endmodule

// ----- bench/tb_retransmit_backoff_timer.sv -----
`timescale 1ns / 100ps

module tb_retransmit_backoff_timer;
   import rbt_pkg::*;

   localparam int TW          = DEF_TIME_WIDTH;
   localparam int CW          = DEF_COUNT_WIDTH;
   localparam int FW          = FIELD_COUNT_WIDTH;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 120;
   localparam int HOLD_PHASE  = 6;
   localparam int HOLD_CYCLES = 400;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      action_type    action;
      logic          dup_accepted;
      logic          sched_valid;
      logic [TW-1:0] sched_delay;
      logic [FW-1:0] total;
      logic          cancel;
   } outcome_type;

   typedef struct packed {
      mode_type      mode;
      logic [TW-1:0] now;
      logic [FW-1:0] dup_limit;
      logic          typed;
      outcome_type   want;
   } stim_row_type;

   logic clock;
   logic reset;

   rbt_req_if #(.TIME_WIDTH(TW)) req_bus ();
   rbt_rsp_if #(.TIME_WIDTH(TW)) rsp_bus ();
   rbt_csr_if #(.DATA_WIDTH(TW)) csr_bus ();

   retransmit_backoff_timer #(
      .TIME_WIDTH  (TW),
      .COUNT_WIDTH (CW)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // register copies
   logic [TW-1:0] cf_base;
   logic [TW-1:0] cf_timeout;
   logic [CW-1:0] cf_max;
   logic          cf_suppress;
   logic          cf_force;
   logic          cf_stream;

   // timer state copies
   logic [CW-1:0] rt_count;
   logic [CW-1:0] dup_count;
   logic [TW-1:0] delay_now;
   logic [TW-1:0] delay_sum;
   logic [TW-1:0] armed_at;
   logic [TW-1:0] limit_time;
   logic [CW-1:0] limit_count;
   logic          last_timed_out;

   outcome_type  pending_outcomes[$];
   stim_row_type directed_rows[$];
   int           mismatches;
   int           cycle_count;
   bit           quiet;
   bit           hold_request;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic grow_delay(input logic [CW:0] cnt);
      if (cnt != 0 && delay_now <= {1'b0, {(TW-1){1'b1}}}) begin
         if ({delay_now[TW-2:0], 1'b0} < limit_time)
            delay_now = {delay_now[TW-2:0], 1'b0};
      end
   endtask

   task automatic compute_outcome(input mode_type m, input logic [TW-1:0] now,
                                  input logic [FW-1:0] dl, output outcome_type o);
      logic [CW:0]   cnt;
      logic [TW-1:0] waited;
      logic [TW:0]   sum;
      o   = '0;
      cnt = {1'b0, rt_count} + {1'b0, dup_count};
      case (m)
         MODE_CLEAR: begin
            rt_count    = '0;
            dup_count   = '0;
            limit_count = '0;
            delay_now   = '0;
            armed_at    = '0;
            limit_time  = '0;
            o.cancel    = 1'b1;
         end
         MODE_START: begin
            rt_count      = '0;
            dup_count     = '0;
            limit_count   = cf_max;
            limit_time    = cf_timeout;
            delay_now     = cf_suppress ? cf_timeout : cf_base;
            armed_at      = now;
            delay_sum     = delay_now;
            o.sched_valid = 1'b1;
            o.sched_delay = delay_now;
         end
         MODE_EXPIRY: begin
            if (cf_force) begin
               o.action = ACT_FORCED;
            end else if (cf_stream) begin
               o.action = ACT_SKIPPED;
            end else begin
               waited = now - armed_at;
               if (cnt >= {1'b0, limit_count} || waited >= limit_time ||
                   delay_sum >= limit_time) begin
                  o.action = ACT_TIMEOUT;
               end else begin
                  grow_delay(cnt);
                  if (!(&rt_count))
                     rt_count = rt_count + CW'(1);
                  sum           = {1'b0, delay_sum} + {1'b0, delay_now};
                  delay_sum     = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
                  o.action      = ACT_RETRANSMIT;
                  o.sched_valid = 1'b1;
                  o.sched_delay = delay_now;
               end
            end
         end
         default: begin
            if (cnt < {1'b0, dl}) begin
               grow_delay(cnt);
               if (!(&dup_count))
                  dup_count = dup_count + CW'(1);
               o.dup_accepted = 1'b1;
            end
         end
      endcase
      cnt            = {1'b0, rt_count} + {1'b0, dup_count};
      o.total        = (cnt > {1'b0, {CW{1'b1}}}) ? {FW{1'b1}} : cnt[FW-1:0];
      last_timed_out = (o.action == ACT_TIMEOUT);
   endtask

   function automatic stim_row_type mk_row(input mode_type m, input logic [TW-1:0] now,
                                           input logic [FW-1:0] dl, input logic typed,
                                           input action_type a, input logic acc,
                                           input logic sv, input logic [TW-1:0] sd,
                                           input logic [FW-1:0] tc, input logic cx);
      stim_row_type r;
      r.mode              = m;
      r.now               = now;
      r.dup_limit         = dl;
      r.typed             = typed;
      r.want.action       = a;
      r.want.dup_accepted = acc;
      r.want.sched_valid  = sv;
      r.want.sched_delay  = sd;
      r.want.total        = tc;
      r.want.cancel       = cx;
      return r;
   endfunction

   task automatic csr_write(input csr_index_type idx, input logic [TW-1:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_BASE_INTERVAL:      cf_base     = value;
         CSR_TOTAL_TIMEOUT:      cf_timeout  = value;
         CSR_MAX_RETRANSMITS:    cf_max      = value[CW-1:0];
         CSR_SUPPRESS_MODE:      cf_suppress = value[0];
         CSR_FORCE_TIMEOUT_MODE: cf_force    = value[0];
         CSR_STREAM_TRANSPORT:   cf_stream   = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [TW-1:0] base, input logic [TW-1:0] tmo,
                                 input logic [CW-1:0] max_rt, input logic sup,
                                 input logic frc, input logic strm);
      csr_write(CSR_BASE_INTERVAL, base);
      csr_write(CSR_TOTAL_TIMEOUT, tmo);
      csr_write(CSR_MAX_RETRANSMITS, TW'(max_rt));
      csr_write(CSR_SUPPRESS_MODE, TW'(sup));
      csr_write(CSR_FORCE_TIMEOUT_MODE, TW'(frc));
      csr_write(CSR_STREAM_TRANSPORT, TW'(strm));
      csr_bus.valid = 1'b0;
   endtask

   // entered and left at a falling edge
   task automatic send_event(input mode_type m, input logic [TW-1:0] now,
                             input logic [FW-1:0] dl, input logic use_want,
                             input outcome_type want);
      outcome_type o;
      if (!quiet && !hold_request && $urandom_range(0, 7) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_bus.valid           = 1'b1;
      req_bus.mode            = m;
      req_bus.now_ms          = now;
      req_bus.duplicate_limit = dl;
      do @(posedge clock); while (!req_bus.ready);
      compute_outcome(m, now, dl, o);
      pending_outcomes.push_back(use_want ? want : o);
      @(negedge clock);
   endtask

   task automatic drain;
      req_bus.valid = 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // receiver
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (!quiet && !reset && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(0, 14)) @(negedge clock);
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result with no request outstanding", $time);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.action !== want.action) begin
               $display("%0t: action exp %0d got %0d", $time, want.action, rsp_bus.action);
               mismatches++;
            end
            if (rsp_bus.duplicate_accepted !== want.dup_accepted) begin
               $display("%0t: duplicate_accepted exp %0d got %0d", $time,
                        want.dup_accepted, rsp_bus.duplicate_accepted);
               mismatches++;
            end
            if (rsp_bus.schedule_valid !== want.sched_valid) begin
               $display("%0t: schedule_valid exp %0d got %0d", $time,
                        want.sched_valid, rsp_bus.schedule_valid);
               mismatches++;
            end
            if (rsp_bus.schedule_delay !== want.sched_delay) begin
               $display("%0t: schedule_delay exp %h got %h", $time,
                        want.sched_delay, rsp_bus.schedule_delay);
               mismatches++;
            end
            if (rsp_bus.total_count !== want.total) begin
               $display("%0t: total_count exp %0d got %0d", $time,
                        want.total, rsp_bus.total_count);
               mismatches++;
            end
            if (rsp_bus.cancel_timer !== want.cancel) begin
               $display("%0t: cancel_timer exp %0d got %0d", $time,
                        want.cancel, rsp_bus.cancel_timer);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL retransmit_backoff_timer");
         $finish;
      end
   end

   initial begin
      int            r;
      logic [TW-1:0] sim_ms;
      logic [TW-1:0] now_v;
      logic [TW-1:0] base_v;
      logic [TW-1:0] tmo_v;
      logic [CW-1:0] max_v;
      logic [FW-1:0] dl_v;
      logic          sup_v;
      logic          frc_v;
      logic          strm_v;
      mode_type      m;

      reset                   = 1'b1;
      quiet                   = 1'b0;
      hold_request            = 1'b0;
      mismatches              = 0;
      cycle_count             = 0;
      req_bus.valid           = 1'b0;
      req_bus.mode            = MODE_CLEAR;
      req_bus.now_ms          = '0;
      req_bus.duplicate_limit = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.index           = '0;
      csr_bus.data            = '0;

      cf_base        = TW'(RESET_BASE_INTERVAL);
      cf_timeout     = TW'(RESET_TOTAL_TIMEOUT);
      cf_max         = CW'(RESET_MAX_RETRANSMITS);
      cf_suppress    = 1'b0;
      cf_force       = 1'b0;
      cf_stream      = 1'b0;
      rt_count       = '0;
      dup_count      = '0;
      delay_now      = '0;
      delay_sum      = '0;
      armed_at       = '0;
      limit_time     = '0;
      limit_count    = '0;
      last_timed_out = 1'b0;
      sim_ms         = '0;

      // reset register values: 500 ms base, 60000 ms timeout, 12 retransmits
      directed_rows.push_back(mk_row(MODE_EXPIRY, 0, 0, 1, ACT_TIMEOUT, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_DUPLICATE, 0, 0, 1, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_DUPLICATE, 0, 16'hFFFF, 1, ACT_NONE, 1, 0, 0, 1, 0));
      directed_rows.push_back(mk_row(MODE_CLEAR, 0, 0, 1, ACT_NONE, 0, 0, 0, 0, 1));
      directed_rows.push_back(mk_row(MODE_START, 32'hFFFF_FFFF, 16'h1234, 1,
                                     ACT_NONE, 0, 1, 500, 0, 0));
      // wall time wraps past zero
      directed_rows.push_back(mk_row(MODE_EXPIRY, 0, 0, 1, ACT_RETRANSMIT, 0, 1, 500, 1, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 1000, 0, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_DUPLICATE, 1500, 5, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_DUPLICATE, 1600, 3, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 60000, 0, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_START, 0, 16'hFFFF, 1, ACT_NONE, 0, 1, 500, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 100, 0, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 200, 16'h5555, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 300, 0, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 400, 0, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 500, 0, 0, ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 32'hFFFF_FFFF, 0, 0,
                                     ACT_NONE, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_CLEAR, 0, 16'hFFFF, 1, ACT_NONE, 0, 0, 0, 0, 1));
      // no start since the clear: limits are zero
      directed_rows.push_back(mk_row(MODE_EXPIRY, 32'h5555_5555, 0, 1,
                                     ACT_TIMEOUT, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_DUPLICATE, 0, 16'hFFFF, 1, ACT_NONE, 1, 0, 0, 1, 0));
      directed_rows.push_back(mk_row(MODE_START, 32'h8000_0000, 0, 1,
                                     ACT_NONE, 0, 1, 500, 0, 0));
      directed_rows.push_back(mk_row(MODE_EXPIRY, 32'h7FFF_FFFF, 0, 1,
                                     ACT_TIMEOUT, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk_row(MODE_DUPLICATE, 32'hAAAA_AAAA, 16'hAAAA, 0,
                                     ACT_NONE, 0, 0, 0, 0, 0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_event(directed_rows[i].mode, directed_rows[i].now, directed_rows[i].dup_limit,
                    directed_rows[i].typed, directed_rows[i].want);

      for (int p = 1; p <= PHASES; p++) begin
         drain();
         quiet  = (p == PHASES);
         base_v = $urandom_range(1, 3000);
         tmo_v  = $urandom_range(1000, 300000);
         max_v  = CW'($urandom_range(0, 24));
         sup_v  = ($urandom_range(0, 3) == 0);
         frc_v  = ($urandom_range(0, 9) == 0);
         strm_v = ($urandom_range(0, 9) == 0);
         if ($urandom_range(0, 5) == 0) base_v = $urandom;
         if ($urandom_range(0, 5) == 0) tmo_v = $urandom;
         if ($urandom_range(0, 5) == 0) max_v = CW'($urandom);
         case (p)
            1: begin
               base_v = '0; tmo_v = '0; max_v = '0;
               sup_v = 1'b0; frc_v = 1'b0; strm_v = 1'b0;
            end
            2: begin
               base_v = '1; tmo_v = '1; max_v = '1;
               sup_v = 1'b1; frc_v = 1'b0; strm_v = 1'b0;
            end
            3: begin frc_v = 1'b1; strm_v = 1'b1; end
            4: begin frc_v = 1'b0; strm_v = 1'b1; end
            // accumulated delay runs into saturation
            5: begin
               base_v = 32'h9000_0000; tmo_v = '1; max_v = '1;
               sup_v = 1'b0; frc_v = 1'b0; strm_v = 1'b0;
            end
            PHASES: begin frc_v = 1'b0; strm_v = 1'b0; end
            default: ;
         endcase
         apply_settings(base_v, tmo_v, max_v, sup_v, frc_v, strm_v);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == HOLD_PHASE && n == 20)
               hold_request = 1'b1;
            r = $urandom_range(0, 99);
            if (last_timed_out && $urandom_range(0, 9) < 6) m = MODE_START;
            else if (r < 5)  m = MODE_CLEAR;
            else if (r < 14) m = MODE_START;
            else if (r < 66) m = MODE_EXPIRY;
            else             m = MODE_DUPLICATE;
            case ($urandom_range(0, 9))
               0:       ;
               1, 2, 3: sim_ms = sim_ms + $urandom_range(0, 100);
               4, 5, 6: sim_ms = sim_ms + delay_now;
               7, 8:    sim_ms = sim_ms + $urandom_range(0, 20000);
               default: sim_ms = sim_ms + $urandom;
            endcase
            now_v = ($urandom_range(0, 19) == 0) ? $urandom : sim_ms;
            case ($urandom_range(0, 7))
               0:       dl_v = '0;
               1:       dl_v = '1;
               2, 3:    dl_v = FW'($urandom);
               default: dl_v = FW'($urandom_range(0, 32));
            endcase
            send_event(m, now_v, dl_v, 1'b0, '0);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("PASS retransmit_backoff_timer");
      else
         $display("FAIL retransmit_backoff_timer");
      $finish;
   end

endmodule
